/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the semaphore RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define CSFW_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true out of reset.
`define CSFW_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* hw/rtl/csfw_pkg.sv */
// Types and constants for the counting semaphore with waiter queue.
package csfw_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int TASK_ID_BITS_DEF = 8;

    localparam int TASK_ID_W = 8;
    localparam int COUNT_W   = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_RST = 8'd1;

    localparam logic [1:0] REQ_WAIT   = 2'd0;
    localparam logic [1:0] REQ_SIGNAL = 2'd1;
    localparam logic [1:0] REQ_CLOSE  = 2'd2;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    typedef struct packed {
        logic [1:0]           func;
        logic [TASK_ID_W-1:0] task_id;
    } req_t;

    typedef struct packed {
        logic [TASK_ID_W-1:0] reply_task;
        logic [1:0]           reply_kind;
        logic                 last;
    } reply_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

/* hw/rtl/csfw_queue.sv */
// Waiter queue: task id memory with head/tail pointers and fill count.
module csfw_queue #(
    parameter int DEPTH = csfw_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_W  = csfw_pkg::TASK_ID_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [ID_W-1:0]       push_id,
    input  logic                  pop,
    input  logic                  rd_req,
    output logic [ID_W-1:0]       rd_id,
    output csfw_pkg::q_status_t   status
);
    import csfw_pkg::*;

    `include "assert_macros.svh"

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

    logic [ID_W-1:0]   mem [DEPTH];
    logic [ID_W-1:0]   rd_id_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // Writes land at the tail; the head is prefetched when a request is taken.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg] <= push_id;
        end
        if (rd_req) begin
            rd_id_reg <= mem[head_reg];
        end
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (push) begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        if (pop) begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    assign rd_id        = rd_id_reg;
    assign status.empty = (fill_reg == '0);
    assign status.full  = (fill_reg == FILL_MAX);

    `CSFW_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FILL_MAX, "queue fill above depth")
    `CSFW_ASSERT(a_empty_ptrs, aclk, aresetn, (fill_reg == '0) |-> (head_reg == tail_reg), "empty queue with pointers apart")
    `CSFW_NEVER(a_push_pop, aclk, aresetn, push && pop, "push and pop in one cycle")

endmodule

/* hw/rtl/counting_semaphore_fifo_waiters_top.sv */
// Counting semaphore with a FIFO queue of waiting tasks (top level).
//
//  channel | dir | ports                       | payload
//  --------+-----+-----------------------------+-------------------------------
//  request | in  | s_valid, s_ready, s_data    | func, task_id
//  reply   | out | m_valid, m_ready, m_data    | reply_task, reply_kind, last
//  config  | in  | cfg_valid, cfg_ready, cfg_data | initial_count (reloads count)
//
//  One request at a time: accept cycle (queue head prefetched from memory),
//  then an execute cycle; a signal that releases a waiter adds a release
//  state, since the reply register emits one result per cycle when m_ready allows.
//  Execute steps that reply, and release, wait while the reply register is held by m_ready low.
//  Reset: synchronous, active low; count returns to 1, queue empty, open.
//  The queue memory itself is not cleared; entries are used only once written.
module counting_semaphore_fifo_waiters_top #(
    parameter int QUEUE_DEPTH  = csfw_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = csfw_pkg::TASK_ID_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  csfw_pkg::req_t        s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output csfw_pkg::reply_t      m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data
);
    import csfw_pkg::*;

    `include "assert_macros.svh"

    localparam int ID_W = (TASK_ID_BITS < TASK_ID_W) ? TASK_ID_BITS : TASK_ID_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_REL  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [1:0]         func_reg;
    logic [ID_W-1:0]    task_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               closed_reg, closed_next;
    logic               m_valid_reg, m_valid_next;
    reply_t             m_data_reg, m_data_next;

    logic               take;
    logic               slot_free;
    logic               emit;
    reply_t             emit_data;
    logic               push, pop;
    logic [ID_W-1:0]    head_id;
    q_status_t          q_stat;

    assign take      = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (take) begin
            func_reg <= s_data.func;
            task_reg <= s_data.task_id[ID_W-1:0];
        end
    end

    csfw_queue #(
        .DEPTH (QUEUE_DEPTH),
        .ID_W  (ID_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_id (task_reg),
        .pop     (pop),
        .rd_req  (take),
        .rd_id   (head_id),
        .status  (q_stat)
    );

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        closed_next = closed_reg;
        emit        = 1'b0;
        emit_data   = '{reply_task: TASK_ID_W'(task_reg), reply_kind: KIND_ACK, last: 1'b1};
        push        = 1'b0;
        pop         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (closed_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    case (func_reg)
                        REQ_WAIT: begin
                            if (count_reg != '0) begin
                                if (slot_free) begin
                                    emit       = 1'b1;
                                    count_next = count_reg - 1'b1;
                                    state_next = ST_IDLE;
                                end
                            end else if (q_stat.full) begin
                                if (slot_free) begin
                                    emit                 = 1'b1;
                                    emit_data.reply_kind = KIND_REJECT;
                                    state_next           = ST_IDLE;
                                end
                            end else begin
                                push       = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        REQ_SIGNAL: begin
                            if (slot_free) begin
                                emit = 1'b1;
                                if (q_stat.empty) begin
                                    if (count_reg != COUNT_MAX) begin
                                        count_next = count_reg + 1'b1;
                                    end
                                    state_next = ST_IDLE;
                                end else begin
                                    emit_data.last = 1'b0;
                                    state_next     = ST_REL;
                                end
                            end
                        end
                        REQ_CLOSE: begin
                            if (slot_free) begin
                                emit        = 1'b1;
                                closed_next = 1'b1;
                                state_next  = ST_IDLE;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_REL: begin
                if (slot_free) begin
                    emit                 = 1'b1;
                    emit_data.reply_task = TASK_ID_W'(head_id);
                    emit_data.reply_kind = KIND_RELEASE;
                    pop                  = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // config write reloads the count directly
        if (cfg_valid && cfg_ready) begin
            count_next = cfg_data;
        end
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_data;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= COUNT_RST;
            closed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            closed_reg  <= closed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `CSFW_ASSERT(a_rel_nonempty, aclk, aresetn, (state_reg == ST_REL) |-> !q_stat.empty, "release with empty queue")
    `CSFW_ASSERT(a_rel_after_ack, aclk, aresetn, $rose(state_reg == ST_REL) |-> (m_valid_reg && !m_data_reg.last), "release not preceded by open ack")
    `CSFW_ASSERT(a_closed_sticks, aclk, aresetn, closed_reg |=> closed_reg, "closed flag dropped")
    `CSFW_NEVER(a_emit_busy, aclk, aresetn, emit && !slot_free, "reply overwritten while stalled")

endmodule
